@@ hdl/sdpw_pkg.sv @@
// Shared types and constants for the step detector peak window block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sdpw_pkg;

   localparam int SAMPLE_W    = 16;
   localparam int SENS_W      = 16;
   localparam int COUNT_W     = 16;
   localparam int THRESH_W    = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int QUEUE_DEPTH = 2;
   localparam int TAPS        = 4;
   localparam int TAP_SHIFT   = $clog2(TAPS);
   localparam int FIRST_SMOOTHED = TAPS - 1;

   localparam logic [SENS_W-1:0] SENS_RESET = 16'd150;

   typedef logic signed [SAMPLE_W-1:0] sample_type;

   typedef struct packed {
      logic [COUNT_W-1:0] step_total;
      logic               step_found;
      logic               window_done;
   } sdpw_result_type;

endpackage

`default_nettype wire

@@ hdl/step_detector_peak_window.sv @@
// Top level of the step detector: sensitivity register, front queue, back end, output word.
// Depends on sdpw_pkg, sdpw_front and sdpw_back.
`default_nettype none

// Step detector over a two-half window of 2*HALF_WINDOW acceleration samples. Each
// accepted req word carries one signed sample; each produces exactly one rsp word in
// order. A sample that does not complete the window is stored and its word offered
// in the cycle it leaves the queue. The sample that fills the window starts an
// evaluation: the window memory is read one entry a cycle over both halves, each
// half smoothed by a 4-tap moving average from its fourth entry on (the smoothed
// second half written back), the qualified peak of the first half and trough of the
// second half tracked on the fly, then the step decision is taken. The scan uses the
// single read port. Evaluations recur every HALF_WINDOW or 2*HALF_WINDOW words. The
// two-word input queue takes up to two further words while the back end works, then
// req_tready drops. The rsp register holds one finished word; the back end hands on
// the next word only when that register is empty or its word leaves in the same
// cycle. Write sensitivity with csr_wr_en only while the block is idle; it resets
// to 150.
module step_detector_peak_window
   import sdpw_pkg::*;
#(
   parameter int HALF_WINDOW = 12
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [SAMPLE_W-1:0]   req_tdata,   // [15:0] sample
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // [0] window_done, [1] step_found,
                                                   // [17:2] step_total, [23:18] zero
   input  wire logic                  csr_wr_en,
   input  wire logic [SENS_W-1:0]     csr_wr_data
);

   logic [SENS_W-1:0] sens_ff, sens_in;
   logic              out_v_ff, out_v_in;
   sdpw_result_type   out_ff, out_in;

   logic              q_valid, q_pop;
   sample_type        q_word;
   logic              res_valid, res_ready;
   sdpw_result_type   res;

   logic [COUNT_W-1:0] u_back_total_probe;
   logic [COUNT_W-1:0] last_total_ff;

   // hold the sensitivity until the next write
   assign sens_in = csr_wr_en ? csr_wr_data : sens_ff;

   sdpw_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_word  (req_tdata),
      .q_valid  (q_valid),
      .q_word   (q_word),
      .q_pop    (q_pop)
   );

   sdpw_back #(
      .HALF_WINDOW (HALF_WINDOW)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .sensitivity (sens_ff),
      .q_valid     (q_valid),
      .q_word      (q_word),
      .q_pop       (q_pop),
      .res_valid   (res_valid),
      .res_ready   (res_ready),
      .res         (res)
   );

   // the output register takes a new word when empty or when its word leaves now
   assign res_ready = !out_v_ff || rsp_tready;

   always_comb begin
      out_v_in = out_v_ff;
      out_in   = out_ff;
      if (res_valid) begin
         out_v_in = 1'b1;
         out_in   = res;
      end else if (rsp_tready) begin
         out_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sens_ff  <= SENS_RESET;
         out_v_ff <= 1'b0;
      end else begin
         sens_ff  <= sens_in;
         out_v_ff <= out_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {(RSP_DATA_W - COUNT_W - 2)'(0), out_ff.step_total,
                        out_ff.step_found, out_ff.window_done};

   // track the step total of the last word handed on
   always_ff @(posedge clock) begin
      if (reset) begin
         last_total_ff <= '0;
      end else if (res_valid) begin
         last_total_ff <= res.step_total;
      end
   end
   assign u_back_total_probe = last_total_ff;

   // the back end never offers a word that the output register cannot take
   a_res_fits: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> res_ready)
      else $error("result offered while output register blocked");

   // a step is only reported from a window evaluation
   a_found_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tdata[1] || rsp_tdata[0]))
      else $error("step_found without window_done");

   // a word that did not finish a window leaves the step count unchanged
   a_total_hold: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !res.window_done) |-> (res.step_total == u_back_total_probe))
      else $error("step_total changed without an evaluation");

endmodule

`default_nettype wire

@@ hdl/sdpw_front.sv @@
// Front end: accepts sample words and holds them in a short queue for the back end.
// Depends on sdpw_pkg.
`default_nettype none

module sdpw_front
   import sdpw_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   output logic            in_ready,
   input  wire sample_type in_word,
   output logic            q_valid,
   output sample_type      q_word,
   input  wire logic       q_pop
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   sample_type       slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             push, pop;

   assign in_ready = (cnt_ff != CNT_W'(QUEUE_DEPTH));
   assign q_valid  = (cnt_ff != '0);
   assign q_word   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;
   assign pop      = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_word;
      end
   end

endmodule

`default_nettype wire

@@ hdl/sdpw_back.sv @@
// Back end: window memory, smoothing scan, peak and trough search, step decision.
// Depends on sdpw_pkg.
`default_nettype none

module sdpw_back
   import sdpw_pkg::*;
#(
   parameter int HALF_WINDOW = 12
)(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [SENS_W-1:0] sensitivity,
   input  wire logic              q_valid,
   input  wire sample_type        q_word,
   output logic                   q_pop,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output sdpw_result_type        res
);

   localparam int DEPTH = 2 * HALF_WINDOW;
   localparam int AW    = $clog2(DEPTH);
   localparam int OW    = $clog2(HALF_WINDOW);

   typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DECIDE} state_type;

   function automatic logic [AW-1:0] phys_addr(input logic hsel, input logic [OW-1:0] off);
      return (hsel ? AW'(HALF_WINDOW) : '0) + AW'(off);
   endfunction

   // control
   state_type          state_ff, state_in;
   logic               bank_ff, bank_in;
   logic [AW-1:0]      fill_ff, fill_in;
   logic [THRESH_W-1:0] thr_ff, thr_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic               iss_on_ff, iss_on_in;
   logic               v1_ff, v2_ff;

   // datapath
   logic               iss_half_ff, iss_half_in;
   logic [OW-1:0]      iss_off_ff, iss_off_in;
   logic               half1_ff, last1_ff, half2_ff, last2_ff;
   logic [OW-1:0]      off1_ff, off2_ff;
   sample_type         r1_ff, r2_ff, r3_ff;
   sample_type         sm_ff, sm_in;
   sample_type         mx_ff, mx_in, mn_ff, mn_in;

   // memory ports
   sample_type         mem [DEPTH];
   sample_type         rdata_ff;
   logic               mem_we, rd_en;
   logic [AW-1:0]      waddr, raddr;
   sample_type         wdata;

   logic               fill_half;
   logic [OW-1:0]      fill_off;
   logic signed [17:0] tap_sum, tap_adj, tap_q;
   logic signed [18:0] up_lim, dn_lim, sm_ext;
   logic               ge;
   logic [THRESH_W:0]  swing;
   logic               step;

   assign fill_half = (fill_ff >= AW'(HALF_WINDOW));
   assign fill_off  = fill_half ? OW'(fill_ff - AW'(HALF_WINDOW)) : OW'(fill_ff);

   // 4-tap average on the raw neighbours, truncated toward zero
   assign tap_sum = {{2{rdata_ff[SAMPLE_W-1]}}, rdata_ff} + {{2{r1_ff[SAMPLE_W-1]}}, r1_ff}
                  + {{2{r2_ff[SAMPLE_W-1]}}, r2_ff} + {{2{r3_ff[SAMPLE_W-1]}}, r3_ff};
   assign tap_adj = tap_sum + (tap_sum[17] ? 18'(TAPS - 1) : 18'd0);
   assign tap_q   = tap_adj >>> TAP_SHIFT;

   assign up_lim = signed'({3'b000, thr_ff}) + signed'({4'b0000, sensitivity[SENS_W-1:1]});
   assign dn_lim = signed'({3'b000, thr_ff}) - signed'({4'b0000, sensitivity[SENS_W-1:1]});
   assign sm_ext = {{3{sm_ff[SAMPLE_W-1]}}, sm_ff};

   assign ge    = (mx_ff >= mn_ff);
   assign swing = {mx_ff[SAMPLE_W-1], mx_ff} - {mn_ff[SAMPLE_W-1], mn_ff};
   assign step  = ge && (swing[THRESH_W-1:0] > sensitivity);

   always_comb begin
      state_in    = state_ff;
      bank_in     = bank_ff;
      fill_in     = fill_ff;
      thr_in      = thr_ff;
      cnt_in      = cnt_ff;
      iss_on_in   = iss_on_ff;
      iss_half_in = iss_half_ff;
      iss_off_in  = iss_off_ff;
      mx_in       = mx_ff;
      mn_in       = mn_ff;
      sm_in       = (off1_ff < OW'(FIRST_SMOOTHED)) ? rdata_ff : tap_q[SAMPLE_W-1:0];
      q_pop       = 1'b0;
      res_valid   = 1'b0;
      res         = '{step_total: cnt_ff, step_found: 1'b0, window_done: 1'b0};
      mem_we      = 1'b0;
      waddr       = phys_addr(fill_half ^ bank_ff, fill_off);
      wdata       = q_word;
      rd_en       = 1'b0;
      raddr       = phys_addr(iss_half_ff ^ bank_ff, iss_off_ff);
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && res_ready) begin
               q_pop  = 1'b1;
               mem_we = 1'b1;
               if (fill_ff == AW'(DEPTH - 1)) begin
                  state_in    = ST_SCAN;
                  iss_on_in   = 1'b1;
                  iss_half_in = 1'b0;
                  iss_off_in  = '0;
               end else begin
                  fill_in   = fill_ff + 1'b1;
                  res_valid = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            if (iss_on_ff) begin
               rd_en = 1'b1;
               if (iss_off_ff == OW'(HALF_WINDOW - 1)) begin
                  iss_off_in = '0;
                  if (iss_half_ff) begin
                     iss_on_in = 1'b0;
                  end else begin
                     iss_half_in = 1'b1;
                  end
               end else begin
                  iss_off_in = iss_off_ff + 1'b1;
               end
            end
            if (v2_ff) begin
               if (!half2_ff) begin
                  if (off2_ff == '0) begin
                     mx_in = sm_ff;
                  end else if (sm_ff > mx_ff && sm_ext > up_lim) begin
                     mx_in = sm_ff;
                  end
               end else begin
                  // keep the smoothed second half: it becomes the next first half
                  mem_we = 1'b1;
                  waddr  = phys_addr(!bank_ff, off2_ff);
                  wdata  = sm_ff;
                  if (off2_ff == '0) begin
                     mn_in = sm_ff;
                  end else if (sm_ff < mn_ff && sm_ext < dn_lim) begin
                     mn_in = sm_ff;
                  end
               end
               if (last2_ff) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (res_ready) begin
               res_valid = 1'b1;
               state_in  = ST_IDLE;
               if (step) begin
                  thr_in  = swing[THRESH_W-1:0];
                  cnt_in  = cnt_ff + 1'b1;
                  fill_in = '0;
               end else begin
                  bank_in = !bank_ff;
                  fill_in = AW'(HALF_WINDOW);
               end
               res = '{step_total: cnt_in, step_found: step, window_done: 1'b1};
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         bank_ff   <= 1'b0;
         fill_ff   <= '0;
         thr_ff    <= '0;
         cnt_ff    <= '0;
         iss_on_ff <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
      end else begin
         state_ff  <= state_in;
         bank_ff   <= bank_in;
         fill_ff   <= fill_in;
         thr_ff    <= thr_in;
         cnt_ff    <= cnt_in;
         iss_on_ff <= iss_on_in;
         v1_ff     <= iss_on_ff;
         v2_ff     <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      iss_half_ff <= iss_half_in;
      iss_off_ff  <= iss_off_in;
      half1_ff    <= iss_half_ff;
      off1_ff     <= iss_off_ff;
      last1_ff    <= iss_half_ff && (iss_off_ff == OW'(HALF_WINDOW - 1));
      half2_ff    <= half1_ff;
      off2_ff     <= off1_ff;
      last2_ff    <= last1_ff;
      mx_ff       <= mx_in;
      mn_ff       <= mn_in;
      if (v1_ff) begin
         sm_ff <= sm_in;
         r1_ff <= rdata_ff;
         r2_ff <= r1_ff;
         r3_ff <= r2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[waddr] <= wdata;
      end
      if (rd_en) begin
         rdata_ff <= mem[raddr];
      end
   end

endmodule

`default_nettype wire
